### rtl/mcmr_pkg.sv
package mcmr_pkg;

  // Channel state codes
  typedef enum logic [1:0] {
    CH_IDLE = 2'd0,
    CH_BUSY = 2'd1,
    CH_COLL = 2'd2
  } chan_state_t;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_EDGE         = 2'd0,
    CMD_TIMEOUT      = 2'd1,
    CMD_BACKOFF_DONE = 2'd2,
    CMD_CLEAR_BYTE   = 2'd3
  } cmd_t;

  localparam logic [15:0] THRESH_RESET = 16'd1000;

  // Monitor / receiver state
  typedef struct packed {
    chan_state_t chan;
    logic        prev_level;
    logic        cur_level;
    logic        edge_seen;
    logic        receiving;
    logic [15:0] last_edge_time;
    logic        backoff_running;
    logic [7:0]  byte_shift;
    logic [2:0]  bit_index;
  } mon_state_t;

  // One result beat
  typedef struct packed {
    logic [1:0]  channel_state;
    logic        backoff_start;
    logic [15:0] backoff_seed;
    logic        backoff_active;
    logic        bit_valid;
    logic        bit_value;
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic        last;
  } rx_result_t;

endpackage

### rtl/mcmr_if.sv
// Event input channel
interface mcmr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        line_level;
  logic [15:0] timestamp;

  modport source (output valid, cmd, line_level, timestamp, input ready);
  modport sink   (input valid, cmd, line_level, timestamp, output ready);
endinterface

// Result output channel
interface mcmr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  channel_state;
  logic        backoff_start;
  logic [15:0] backoff_seed;
  logic        backoff_active;
  logic        bit_valid;
  logic        bit_value;
  logic        byte_valid;
  logic [7:0]  byte_value;
  logic        last;

  modport source (output valid, channel_state, backoff_start, backoff_seed, backoff_active,
                  bit_valid, bit_value, byte_valid, byte_value, last, input ready);
  modport sink   (input valid, channel_state, backoff_start, backoff_seed, backoff_active,
                  bit_valid, bit_value, byte_valid, byte_value, last, output ready);
endinterface

### rtl/manchester_channel_monitor_rx_unit.sv
// Channel | Dir | Payload
// in_ch   | in  | cmd, line_level, timestamp
// out_ch  | out | channel_state, backoff flags/seed, bit, byte, last
// cfg_*   | in  | edge_spacing_threshold write
//
// One event per cycle while out_ch is ready: an input register feeds the
// event logic, whose results land in a two-entry output register. An
// edge yielding two bits takes two output beats; input stalls meanwhile.
// Events pass the input register, then the output register, to out_ch.
// rst_n is synchronous; state returns to busy, threshold to 1000.
module manchester_channel_monitor_rx_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  mcmr_in_if.sink       in_ch,
  mcmr_out_if.source    out_ch
);
  import mcmr_pkg::*;

  logic [15:0] thresh_r;
  mon_state_t  st_r;
  mon_state_t  st_nxt;
  logic        in_vld_r;
  cmd_t        cmd_r;
  logic        lvl_r;
  logic [15:0] ts_r;
  logic        o_vld_r;
  logic        o_pend_r;
  rx_result_t  res0_r;
  rx_result_t  res1_r;
  rx_result_t  new0;
  rx_result_t  new1;
  logic        two;
  logic        out_free;
  logic        advance;
  logic        in_fire;
  logic        out_fire;

  assign out_fire = o_vld_r & out_ch.ready;
  assign out_free = !o_vld_r || (out_ch.ready && !o_pend_r);
  assign advance  = in_vld_r & out_free;
  assign in_ch.ready = !in_vld_r || advance;
  assign in_fire  = in_ch.valid & in_ch.ready;

  mcmr_event_logic u_evt (
    .st_i         (st_r),
    .thresh_i     (thresh_r),
    .cmd_i        (cmd_r),
    .line_level_i (lvl_r),
    .timestamp_i  (ts_r),
    .st_o         (st_nxt),
    .res0_o       (new0),
    .res1_o       (new1),
    .two_o        (two)
  );

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // Monitor state, updated when an event moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.chan            <= CH_BUSY;
      st_r.prev_level      <= 1'b1;
      st_r.cur_level       <= 1'b1;
      st_r.edge_seen       <= 1'b0;
      st_r.receiving       <= 1'b0;
      st_r.last_edge_time  <= '0;
      st_r.backoff_running <= 1'b0;
      st_r.byte_shift      <= '0;
      st_r.bit_index       <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd_t'(in_ch.cmd);
      lvl_r <= in_ch.line_level;
      ts_r  <= in_ch.timestamp;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r  <= 1'b0;
      o_pend_r <= 1'b0;
    end else if (advance) begin
      o_vld_r  <= 1'b1;
      o_pend_r <= two;
    end else if (out_fire) begin
      if (o_pend_r) begin
        o_pend_r <= 1'b0;
      end else begin
        o_vld_r <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res0_r <= new0;
      res1_r <= new1;
    end else if (out_fire && o_pend_r) begin
      res0_r <= res1_r;
    end
  end

  assign out_ch.valid          = o_vld_r;
  assign out_ch.channel_state  = res0_r.channel_state;
  assign out_ch.backoff_start  = res0_r.backoff_start;
  assign out_ch.backoff_seed   = res0_r.backoff_seed;
  assign out_ch.backoff_active = res0_r.backoff_active;
  assign out_ch.bit_valid      = res0_r.bit_valid;
  assign out_ch.bit_value      = res0_r.bit_value;
  assign out_ch.byte_valid     = res0_r.byte_valid;
  assign out_ch.byte_value     = res0_r.byte_value;
  assign out_ch.last           = res0_r.last;

endmodule

### rtl/mcmr_event_logic.sv
module mcmr_event_logic (
  input  mcmr_pkg::mon_state_t st_i,
  input  logic [15:0]          thresh_i,
  input  mcmr_pkg::cmd_t       cmd_i,
  input  logic                 line_level_i,
  input  logic [15:0]          timestamp_i,
  output mcmr_pkg::mon_state_t st_o,
  output mcmr_pkg::rx_result_t res0_o,
  output mcmr_pkg::rx_result_t res1_o,
  output logic                 two_o
);
  import mcmr_pkg::*;

  mon_state_t  st;
  logic        bstart;
  logic [15:0] seed;
  logic        zero_bit;
  logic        level_bit;
  logic [15:0] delta;
  logic        has_a;
  logic        bit_a;
  logic [7:0]  shift_a;
  logic [2:0]  idx_a;
  logic [7:0]  shift_b;
  logic [2:0]  idx_b;

  assign delta = timestamp_i - st_i.last_edge_time;

  // Channel state and reception control
  always_comb begin
    st        = st_i;
    bstart    = 1'b0;
    seed      = '0;
    zero_bit  = 1'b0;
    level_bit = 1'b0;
    case (cmd_i)
      CMD_EDGE: begin
        st.prev_level = st_i.cur_level;
        st.cur_level  = line_level_i;
        st.edge_seen  = 1'b1;
        st.chan       = CH_BUSY;
        case (st_i.chan)
          CH_COLL: begin
            st.backoff_running = 1'b1;
            bstart             = 1'b1;
            seed               = timestamp_i;
          end
          CH_IDLE: begin
            // falling edge on an idle line opens a frame
            if (st_i.cur_level && !line_level_i) st.receiving = 1'b1;
          end
          default: ;
        endcase
        if (st.receiving) begin
          zero_bit = (line_level_i == st_i.cur_level);
          if (delta >= thresh_i) begin
            level_bit         = 1'b1;
            st.last_edge_time = timestamp_i;
          end
        end
      end
      CMD_TIMEOUT: begin
        // quiet period ends reception; line level tells idle from collision
        if (!st_i.edge_seen && st_i.chan != CH_IDLE && st_i.chan != CH_COLL) begin
          st.receiving = 1'b0;
          st.chan      = line_level_i ? CH_IDLE : CH_COLL;
        end
        st.edge_seen = 1'b0;
      end
      CMD_BACKOFF_DONE: begin
        st.backoff_running = 1'b0;
      end
      default: begin
        st.byte_shift = '0;
        st.bit_index  = '0;
      end
    endcase
  end

  // Bit packing: inserted zero bit goes first, level bit second
  always_comb begin
    has_a   = zero_bit | level_bit;
    bit_a   = zero_bit ? 1'b0 : line_level_i;
    shift_a = has_a ? {st.byte_shift[6:0], bit_a} : st.byte_shift;
    idx_a   = has_a ? st.bit_index + 3'd1 : st.bit_index;
    shift_b = {shift_a[6:0], line_level_i};
    idx_b   = idx_a + 3'd1;

    res0_o.channel_state  = st.chan;
    res0_o.backoff_start  = bstart;
    res0_o.backoff_seed   = seed;
    res0_o.backoff_active = st.backoff_running;
    res0_o.bit_valid      = has_a;
    res0_o.bit_value      = has_a & bit_a;
    res0_o.byte_valid     = has_a && (idx_a == 3'd0);
    res0_o.byte_value     = (has_a && (idx_a == 3'd0)) ? shift_a : 8'd0;
    res0_o.last           = !two_o;

    res1_o                = res0_o;
    res1_o.bit_valid      = 1'b1;
    res1_o.bit_value      = line_level_i;
    res1_o.byte_valid     = (idx_b == 3'd0);
    res1_o.byte_value     = (idx_b == 3'd0) ? shift_b : 8'd0;
    res1_o.last           = 1'b1;

    st_o            = st;
    st_o.byte_shift = two_o ? shift_b : shift_a;
    st_o.bit_index  = two_o ? idx_b : idx_a;
  end

  assign two_o = zero_bit & level_bit;

endmodule
